@@ sv/pfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types, codes and defaults of the page frame replacement block.
// ----------------------------------------------------------------------------
package pfr_pkg;

    localparam int MAX_FRAMES_DEF = 64;
    localparam int NUM_PROCS_DEF  = 4;
    localparam int ADDR_BITS_DEF  = 16;

    localparam int DVD_W = 32;
    localparam int DVS_W = 13;
    localparam int CFG_W = 13;

    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_LRU  = 2'd1;
    localparam logic [1:0] POL_RND  = 2'd2;

    localparam logic [1:0] REG_POLICY    = 2'd0;
    localparam logic [1:0] REG_PAGE_SIZE = 2'd1;
    localparam logic [1:0] REG_FRAMES    = 2'd2;

    localparam logic [1:0]  POLICY_RST    = POL_FIFO;
    localparam logic [12:0] PAGE_SIZE_RST = 13'd10;
    localparam logic [6:0]  FRAMES_RST    = 7'd64;

    typedef struct packed {
        logic [1:0]  process_id;
        logic [15:0] word_address;
        logic [30:0] random_value;
    } t_in_beat;

    typedef struct packed {
        logic        fault;
        logic [5:0]  frame_index;
        logic        evicted;
        logic [1:0]  victim_process;
        logic [15:0] victim_page;
        logic [31:0] victim_residency;
        logic [31:0] fault_count;
    } t_out_beat;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV_PAGE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FAULT,
        S_DIV_RND,
        S_VSCAN_RD,
        S_VSCAN_CHK,
        S_VRD,
        S_VCAP,
        S_FIND_RD,
        S_FIND_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUSH,
        S_WRITE,
        S_DONE
    } t_state;

endpackage

@@ sv/page_frame_replacement.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_frame_replacement
// Demand paging frame table with FIFO, LRU or random replacement.
// ----------------------------------------------------------------------------
// channel  direction  beat         handshake
// in       input      t_in_beat    i_in_valid / o_in_ready
// out      output     t_out_beat   o_out_valid / i_out_ready
// cfg      input      index, data  i_cfg_we
//
// One reference at a time: page divide, then a scan of the frame table,
// then on a fault with no free frame a random divide (random policy) or
// a scan of the order list, and a victim read; a fault or an LRU hit
// searches and shifts the order list, then push, write (fault only),
// result load. The frame and order RAMs each have a single read port.
// Synchronous active-low reset; no clearing pass. The next reference is
// taken while a result waits in the output register.
// ----------------------------------------------------------------------------
module page_frame_replacement #(
    parameter int MAX_FRAMES = pfr_pkg::MAX_FRAMES_DEF,
    parameter int NUM_PROCS  = pfr_pkg::NUM_PROCS_DEF,
    parameter int ADDR_BITS  = pfr_pkg::ADDR_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  pfr_pkg::t_in_beat         i_in_beat,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output pfr_pkg::t_out_beat        o_out_beat,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [pfr_pkg::CFG_W-1:0] i_cfg_data
);

    localparam int FW   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW   = $clog2(MAX_FRAMES + 1);
    localparam int PIDW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int PW   = ADDR_BITS;
    localparam int FRW  = PIDW + PW + 32;

    pfr_pkg::t_state r_state, n_state;

    logic [1:0]   r_policy;
    logic [12:0]  r_page_size;
    logic [6:0]   r_frames;

    logic [PIDW-1:0] r_pid, n_pid;
    logic [30:0]     r_rnd, n_rnd;
    logic [PW-1:0]   r_page, n_page;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_pos, n_pos;
    logic [CW-1:0]   r_len, n_len;
    logic [FW-1:0]   r_f, n_f;
    logic [FW-1:0]   r_free, n_free;
    logic            r_has_free, n_has_free;
    logic            r_fault, n_fault;
    logic            r_evict, n_evict;
    logic [PIDW-1:0] r_vproc, n_vproc;
    logic [PW-1:0]   r_vpage, n_vpage;
    logic [31:0]     r_vres, n_vres;
    logic [31:0]     r_time, n_time;
    logic [31:0]     r_ft [NUM_PROCS];
    logic            r_ft_inc, n_ft_inc;
    logic            r_used [MAX_FRAMES];
    logic            set_used;
    logic            r_ov, n_ov;
    pfr_pkg::t_out_beat r_ob, n_ob;

    logic                      div_start;
    logic [pfr_pkg::DVD_W-1:0] div_dvd;
    logic [pfr_pkg::DVS_W-1:0] div_dvs;
    logic                      div_done;
    logic [pfr_pkg::DVD_W-1:0] div_quot;
    logic [pfr_pkg::DVS_W-1:0] div_rem;

    logic            fr_we;
    logic [FW-1:0]   fr_raddr;
    logic [FRW-1:0]  fr_wdata, fr_rdata;
    logic            ol_we;
    logic [FW-1:0]   ol_waddr, ol_raddr;
    logic [FW-1:0]   ol_wdata, ol_rdata;

    logic [PIDW-1:0] rd_owner;
    logic [PW-1:0]   rd_page;
    logic [31:0]     rd_loaded;
    logic [PIDW-1:0] pid_mod;
    logic [2:0]      pid_tmp;
    logic [CW-1:0]   n_clamp;
    logic [12:0]     ps_eff;

    assign rd_owner  = fr_rdata[FRW-1 -: PIDW];
    assign rd_page   = fr_rdata[32 +: PW];
    assign rd_loaded = fr_rdata[31:0];

    always_comb begin
        pid_tmp = {1'b0, i_in_beat.process_id};
        for (int k = 0; k < 3; k++) begin
            if (32'(pid_tmp) >= NUM_PROCS) begin
                pid_tmp = 3'(32'(pid_tmp) - NUM_PROCS);
            end
        end
        pid_mod = PIDW'(pid_tmp);
        if (r_frames == 7'd0) begin
            n_clamp = CW'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            n_clamp = CW'(MAX_FRAMES);
        end else begin
            n_clamp = CW'(r_frames);
        end
        ps_eff = (r_page_size == 13'd0) ? 13'd1 : r_page_size;
    end

    pfr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    pfr_ram #(.W(FRW), .D(MAX_FRAMES), .AW(FW)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (r_f),
        .i_wdata (fr_wdata),
        .i_raddr (fr_raddr),
        .o_rdata (fr_rdata)
    );

    pfr_ram #(.W(FW), .D(MAX_FRAMES), .AW(FW)) u_order_ram (
        .i_clk   (i_clk),
        .i_we    (ol_we),
        .i_waddr (ol_waddr),
        .i_wdata (ol_wdata),
        .i_raddr (ol_raddr),
        .o_rdata (ol_rdata)
    );

    assign fr_wdata = {r_pid, r_page, r_time};
    assign o_in_ready = (r_state == pfr_pkg::S_IDLE);

    always_comb begin
        n_state    = r_state;
        n_pid      = r_pid;
        n_rnd      = r_rnd;
        n_page     = r_page;
        n_n        = r_n;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_len      = r_len;
        n_f        = r_f;
        n_free     = r_free;
        n_has_free = r_has_free;
        n_fault    = r_fault;
        n_evict    = r_evict;
        n_vproc    = r_vproc;
        n_vpage    = r_vpage;
        n_vres     = r_vres;
        n_time     = r_time;
        n_ft_inc   = 1'b0;
        n_ob       = r_ob;
        n_ov       = r_ov;
        set_used   = 1'b0;
        div_start  = 1'b0;
        div_dvd    = {16'd0, i_in_beat.word_address};
        div_dvs    = ps_eff;
        fr_we      = 1'b0;
        fr_raddr   = r_idx[FW-1:0];
        ol_we      = 1'b0;
        ol_waddr   = r_len[FW-1:0];
        ol_wdata   = r_f;
        ol_raddr   = r_pos[FW-1:0];

        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            pfr_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_pid     = pid_mod;
                    n_rnd     = i_in_beat.random_value;
                    n_n       = n_clamp;
                    n_fault   = 1'b0;
                    n_evict   = 1'b0;
                    n_vproc   = '0;
                    n_vpage   = '0;
                    n_vres    = '0;
                    div_start = 1'b1;
                    n_state   = pfr_pkg::S_DIV_PAGE;
                end
            end
            pfr_pkg::S_DIV_PAGE: begin
                if (div_done) begin
                    n_page     = div_quot[PW-1:0];
                    n_idx      = '0;
                    n_has_free = 1'b0;
                    n_state    = pfr_pkg::S_SCAN_RD;
                end
            end
            pfr_pkg::S_SCAN_RD: begin
                if (r_idx == r_n) begin
                    n_state = pfr_pkg::S_FAULT;
                end else begin
                    n_state = pfr_pkg::S_SCAN_CHK;
                end
            end
            pfr_pkg::S_SCAN_CHK: begin
                if (r_used[r_idx[FW-1:0]] && rd_owner == r_pid && rd_page == r_page) begin
                    n_f   = r_idx[FW-1:0];
                    n_pos = '0;
                    if (r_policy == pfr_pkg::POL_LRU) begin
                        n_state = pfr_pkg::S_FIND_RD;
                    end else begin
                        n_state = pfr_pkg::S_DONE;
                    end
                end else begin
                    if (!r_used[r_idx[FW-1:0]]) begin
                        n_free     = r_idx[FW-1:0];
                        n_has_free = 1'b1;
                    end
                    n_idx   = r_idx + 1'b1;
                    n_state = pfr_pkg::S_SCAN_RD;
                end
            end
            pfr_pkg::S_FAULT: begin
                n_fault  = 1'b1;
                n_ft_inc = 1'b1;
                n_pos    = '0;
                if (r_has_free) begin
                    n_f     = r_free;
                    n_state = pfr_pkg::S_FIND_RD;
                end else if (r_policy == pfr_pkg::POL_RND) begin
                    div_start = 1'b1;
                    div_dvd   = {1'b0, r_rnd};
                    div_dvs   = pfr_pkg::DVS_W'(r_n);
                    n_state   = pfr_pkg::S_DIV_RND;
                end else begin
                    n_f     = '0;
                    n_state = pfr_pkg::S_VSCAN_RD;
                end
            end
            pfr_pkg::S_DIV_RND: begin
                if (div_done) begin
                    n_f     = div_rem[FW-1:0];
                    n_state = pfr_pkg::S_VRD;
                end
            end
            pfr_pkg::S_VSCAN_RD: begin
                if (r_pos == r_len) begin
                    n_state = pfr_pkg::S_VRD;
                end else begin
                    n_state = pfr_pkg::S_VSCAN_CHK;
                end
            end
            pfr_pkg::S_VSCAN_CHK: begin
                if (32'(ol_rdata) < 32'(r_n)) begin
                    n_f     = ol_rdata;
                    n_state = pfr_pkg::S_VRD;
                end else begin
                    n_pos   = r_pos + 1'b1;
                    n_state = pfr_pkg::S_VSCAN_RD;
                end
            end
            pfr_pkg::S_VRD: begin
                fr_raddr = r_f;
                n_state  = pfr_pkg::S_VCAP;
            end
            pfr_pkg::S_VCAP: begin
                n_evict = 1'b1;
                n_vproc = rd_owner;
                n_vpage = rd_page;
                n_vres  = r_time - rd_loaded;
                n_pos   = '0;
                n_state = pfr_pkg::S_FIND_RD;
            end
            pfr_pkg::S_FIND_RD: begin
                if (r_pos == r_len) begin
                    n_state = pfr_pkg::S_PUSH;
                end else begin
                    n_state = pfr_pkg::S_FIND_CHK;
                end
            end
            pfr_pkg::S_FIND_CHK: begin
                n_pos = r_pos + 1'b1;
                if (ol_rdata == r_f) begin
                    n_state = pfr_pkg::S_SHIFT_RD;
                end else begin
                    n_state = pfr_pkg::S_FIND_RD;
                end
            end
            pfr_pkg::S_SHIFT_RD: begin
                if (r_pos == r_len) begin
                    n_len   = r_len - 1'b1;
                    n_state = pfr_pkg::S_PUSH;
                end else begin
                    n_state = pfr_pkg::S_SHIFT_WR;
                end
            end
            pfr_pkg::S_SHIFT_WR: begin
                ol_we    = 1'b1;
                ol_waddr = FW'(r_pos - 1'b1);
                ol_wdata = ol_rdata;
                n_pos    = r_pos + 1'b1;
                n_state  = pfr_pkg::S_SHIFT_RD;
            end
            pfr_pkg::S_PUSH: begin
                if (32'(r_len) < MAX_FRAMES) begin
                    ol_we = 1'b1;
                    n_len = r_len + 1'b1;
                end
                n_state = r_fault ? pfr_pkg::S_WRITE : pfr_pkg::S_DONE;
            end
            pfr_pkg::S_WRITE: begin
                fr_we    = 1'b1;
                set_used = 1'b1;
                n_state  = pfr_pkg::S_DONE;
            end
            pfr_pkg::S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    n_ov = 1'b1;
                    n_ob.fault            = r_fault;
                    n_ob.evicted          = r_evict;
                    n_ob.victim_residency = r_vres;
                    n_ob.fault_count      = r_ft[r_pid];
                    for (int b = 0; b < 6; b++) begin
                        n_ob.frame_index[b] = (b < FW) ? r_f[b] : 1'b0;
                    end
                    for (int b = 0; b < 2; b++) begin
                        n_ob.victim_process[b] = (b < PIDW) ? r_vproc[b] : 1'b0;
                    end
                    for (int b = 0; b < 16; b++) begin
                        n_ob.victim_page[b] = (b < PW) ? r_vpage[b] : 1'b0;
                    end
                    n_time  = r_time + 1'b1;
                    n_state = pfr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pfr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfr_pkg::S_IDLE;
            r_policy    <= pfr_pkg::POLICY_RST;
            r_page_size <= pfr_pkg::PAGE_SIZE_RST;
            r_frames    <= pfr_pkg::FRAMES_RST;
            r_len       <= '0;
            r_time      <= '0;
            r_ov        <= 1'b0;
            r_ft_inc    <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++) begin
                r_ft[i] <= '0;
            end
            for (int i = 0; i < MAX_FRAMES; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_time   <= n_time;
            r_ov     <= n_ov;
            r_ft_inc <= n_ft_inc;
            if (r_ft_inc && r_ft[r_pid] != 32'hFFFF_FFFF) begin
                r_ft[r_pid] <= r_ft[r_pid] + 1'b1;
            end
            if (set_used) begin
                r_used[r_f] <= 1'b1;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pfr_pkg::REG_POLICY:    r_policy    <= i_cfg_data[1:0];
                    pfr_pkg::REG_PAGE_SIZE: r_page_size <= i_cfg_data;
                    pfr_pkg::REG_FRAMES:    r_frames    <= i_cfg_data[6:0];
                    default: ;
                endcase
            end
        end
        r_pid      <= n_pid;
        r_rnd      <= n_rnd;
        r_page     <= n_page;
        r_n        <= n_n;
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_f        <= n_f;
        r_free     <= n_free;
        r_has_free <= n_has_free;
        r_fault    <= n_fault;
        r_evict    <= n_evict;
        r_vproc    <= n_vproc;
        r_vpage    <= n_vpage;
        r_vres     <= n_vres;
        r_ob       <= n_ob;
    end

    assign o_out_valid = r_ov;
    assign o_out_beat  = r_ob;

    // order list never grows past MAX_FRAMES
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= MAX_FRAMES)
        else $error("order list length out of range");

    a_evict_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_beat.evicted |-> o_out_beat.fault)
        else $error("eviction without fault");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfr_pkg::S_IDLE && !i_in_valid |=> r_state == pfr_pkg::S_IDLE)
        else $error("left idle without a beat");

    a_write_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fr_we |-> r_fault)
        else $error("frame write on a hit");

endmodule

@@ sv/pfr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pfr_pkg::DVD_W-1:0] i_dividend,
    input  logic [pfr_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [pfr_pkg::DVD_W-1:0] o_quot,
    output logic [pfr_pkg::DVS_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(pfr_pkg::DVD_W + 1);

    logic                      r_busy, n_busy;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [pfr_pkg::DVD_W-1:0] r_q, n_q;
    logic [pfr_pkg::DVS_W-1:0] r_rem, n_rem;
    logic [pfr_pkg::DVS_W-1:0] r_dvs, n_dvs;
    logic                      r_done, n_done;
    logic [pfr_pkg::DVS_W:0]   trial;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_done = 1'b0;
        trial  = {r_rem, r_q[pfr_pkg::DVD_W-1]};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = pfr_pkg::DVS_W'(trial - {1'b0, r_dvs});
                n_q   = {r_q[pfr_pkg::DVD_W-2:0], 1'b1};
            end else begin
                n_rem = trial[pfr_pkg::DVS_W-1:0];
                n_q   = {r_q[pfr_pkg::DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (32'(r_cnt) == pfr_pkg::DVD_W - 1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

@@ sv/pfr_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfr_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module pfr_ram #(
    parameter int W  = 8,
    parameter int D  = 64,
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
